@@ hdl/lcbc_pkg.sv @@
package lcbc_pkg;

    // Field widths of the ports.
    localparam int PERIOD_W   = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int BUTTONS_W  = 4;
    localparam int LEDS_W     = 16;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 3;

    // Default LED count.
    localparam int NUM_LEDS_DEFAULT = 16;

    // Register reset values.
    localparam logic [PERIOD_W-1:0]   RST_MIN_PERIOD     = 16'd100;
    localparam logic [PERIOD_W-1:0]   RST_MAX_PERIOD     = 16'd10000;
    localparam logic [PERIOD_W-1:0]   RST_INITIAL_PERIOD = 16'd1000;
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_STEP    = 16'd100;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_TICKS = 8'd10;

    // Button bit positions.
    localparam int BIT_REVERSE = 0;
    localparam int BIT_FASTER  = 1;
    localparam int BIT_SLOWER  = 2;
    localparam int BIT_PAUSE   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PERIOD     = 3'd0,
        REG_MAX_PERIOD     = 3'd1,
        REG_INITIAL_PERIOD = 3'd2,
        REG_PERIOD_STEP    = 3'd3,
        REG_DEBOUNCE_TICKS = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0]   min_period;
        logic [PERIOD_W-1:0]   max_period;
        logic [PERIOD_W-1:0]   period_step;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic                load;
        logic [PERIOD_W-1:0] value;
    } t_period_load;

    typedef struct packed {
        logic [LEDS_W-1:0]   leds;
        logic [POS_W-1:0]    led_position;
        logic                moving_down;
        logic [PERIOD_W-1:0] step_period;
        logic                running;
    } t_result;

endpackage

@@ hdl/lcbc_cfg_regs.sv @@
module lcbc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [lcbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcbc_pkg::PERIOD_W-1:0]       i_cfg_data,
    output lcbc_pkg::t_cfg                      o_cfg,
    output lcbc_pkg::t_period_load              o_period_load
);

    lcbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period     <= lcbc_pkg::RST_MIN_PERIOD;
            r_cfg.max_period     <= lcbc_pkg::RST_MAX_PERIOD;
            r_cfg.period_step    <= lcbc_pkg::RST_PERIOD_STEP;
            r_cfg.debounce_ticks <= lcbc_pkg::RST_DEBOUNCE_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcbc_pkg::REG_MIN_PERIOD:     r_cfg.min_period  <= i_cfg_data;
                lcbc_pkg::REG_MAX_PERIOD:     r_cfg.max_period  <= i_cfg_data;
                lcbc_pkg::REG_PERIOD_STEP:    r_cfg.period_step <= i_cfg_data;
                lcbc_pkg::REG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= i_cfg_data[lcbc_pkg::DEBOUNCE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // The initial period register only matters as a load into the live period,
    // so it is passed on as a one-cycle load strobe.
    assign o_period_load.load  = i_cfg_valid &&
                                 (i_cfg_index == lcbc_pkg::REG_INITIAL_PERIOD);
    assign o_period_load.value = i_cfg_data;
    assign o_cfg               = r_cfg;

endmodule

@@ hdl/lcbc_engine.sv @@
module lcbc_engine #(
    parameter int NUM_LEDS = lcbc_pkg::NUM_LEDS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick,
    input  logic [lcbc_pkg::BUTTONS_W-1:0]   i_buttons,
    input  lcbc_pkg::t_cfg                   i_cfg,
    input  lcbc_pkg::t_period_load           i_period_load,
    output lcbc_pkg::t_result                o_next
);

    localparam int PW = $clog2(NUM_LEDS);
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_LEDS - 1);
    localparam int PERW = lcbc_pkg::PERIOD_W;

    logic [NUM_LEDS-1:0]               r_pattern, n_pattern;
    logic [PW-1:0]                     r_pos, n_pos;
    logic                              r_down, n_down;
    logic [PERW-1:0]                   r_period, n_period;
    logic                              r_run, n_run;
    logic [PERW-1:0]                   r_cnt, n_cnt;
    logic [lcbc_pkg::BUTTONS_W-1:0]    r_last, n_last;
    logic [lcbc_pkg::DEBOUNCE_W-1:0]   r_dcnt, n_dcnt;
    logic                              r_pend, n_pend;
    logic [PERW:0]                     diff;
    logic [PERW:0]                     sum;

    assign diff = {1'b0, r_period} - {1'b0, i_cfg.period_step};
    assign sum  = {1'b0, r_period} + {1'b0, i_cfg.period_step};

    always_comb begin
        n_pattern = r_pattern;
        n_pos     = r_pos;
        n_down    = r_down;
        n_period  = r_period;
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_dcnt    = r_dcnt;
        n_pend    = r_pend;

        // The step comes first and uses the direction and period in force.
        if (r_run) begin
            if (r_cnt == '0) begin
                n_pattern = NUM_LEDS'(1) << r_pos;
                if (r_down) begin
                    n_pos = (r_pos == '0) ? LAST_POS : r_pos - 1'b1;
                end else begin
                    n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                end
                n_cnt = (r_period == '0) ? '0 : r_period - 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end

        if (i_buttons != r_last) begin
            n_last = i_buttons;
            n_dcnt = i_cfg.debounce_ticks;
            n_pend = 1'b1;
        end else if (r_pend) begin
            if (r_dcnt <= 8'd1) begin
                n_pend = 1'b0;
                n_dcnt = '0;
                if (i_buttons[lcbc_pkg::BIT_REVERSE]) begin
                    n_down = ~r_down;
                end else if (i_buttons[lcbc_pkg::BIT_FASTER]) begin
                    // A borrow means the result went below zero, hence below the floor.
                    if (diff[PERW] || (diff[PERW-1:0] < i_cfg.min_period)) begin
                        n_period = i_cfg.min_period;
                    end else begin
                        n_period = diff[PERW-1:0];
                    end
                end else if (i_buttons[lcbc_pkg::BIT_SLOWER]) begin
                    if (sum > {1'b0, i_cfg.max_period}) begin
                        n_period = i_cfg.max_period;
                    end else begin
                        n_period = sum[PERW-1:0];
                    end
                end else if (i_buttons[lcbc_pkg::BIT_PAUSE]) begin
                    n_run = ~r_run;
                    n_cnt = '0;
                end
            end else begin
                n_dcnt = r_dcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_pos     <= '0;
            r_down    <= 1'b0;
            r_period  <= lcbc_pkg::RST_INITIAL_PERIOD;
            r_run     <= 1'b1;
            r_cnt     <= '0;
            r_last    <= '0;
            r_dcnt    <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_tick) begin
                r_pattern <= n_pattern;
                r_pos     <= n_pos;
                r_down    <= n_down;
                r_period  <= n_period;
                r_run     <= n_run;
                r_cnt     <= n_cnt;
                r_last    <= n_last;
                r_dcnt    <= n_dcnt;
                r_pend    <= n_pend;
            end
            if (i_period_load.load) begin
                r_period <= i_period_load.value;
            end
        end
    end

    // Size casts truncate or zero-extend to the port widths as needed.
    assign o_next.leds         = lcbc_pkg::LEDS_W'(n_pattern);
    assign o_next.led_position = lcbc_pkg::POS_W'(n_pos);
    assign o_next.moving_down  = n_down;
    assign o_next.step_period  = n_period;
    assign o_next.running      = n_run;

endmodule

@@ hdl/led_chaser_with_button_control.sv @@
// An accepted tick is held in the input register and moves through the state update into the
// result register. Throughput: one tick per clock cycle while results are taken; the two
// registers hold one item each; the update between them is a single counter and compare pass.
// Reset (i_rst_n low, synchronous): LEDs dark, index 0, counting up, running, period 1000,
// first step due on the first tick, and all configuration registers back to their defaults.
module led_chaser_with_button_control #(
    parameter int NUM_LEDS = lcbc_pkg::NUM_LEDS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Tick input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lcbc_pkg::BUTTONS_W-1:0]    i_buttons,
    // Result output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lcbc_pkg::LEDS_W-1:0]       o_leds,
    output logic [lcbc_pkg::POS_W-1:0]        o_led_position,
    output logic                              o_moving_down,
    output logic [lcbc_pkg::PERIOD_W-1:0]     o_step_period,
    output logic                              o_running,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcbc_pkg::PERIOD_W-1:0]     i_cfg_data
);

    // Input register: holds one accepted tick until the state update can run.
    logic                              r_in_valid;
    logic [lcbc_pkg::BUTTONS_W-1:0]    r_in_buttons;
    // Result register: holds one finished result until the consumer takes it.
    logic                              r_out_valid;
    lcbc_pkg::t_result                 r_out;

    lcbc_pkg::t_cfg                    cfg;
    lcbc_pkg::t_period_load            period_load;
    lcbc_pkg::t_result                 next_result;
    logic                              advance;

    // A tick moves into the state update whenever the result register is free
    // or is being emptied in this same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    // The input register accepts a new transfer when it is empty or draining.
    assign o_in_ready = !r_in_valid || advance;
    // Configuration writes are always taken; the user must send them only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    lcbc_cfg_regs u_cfg_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg),
        .o_period_load (period_load)
    );

    lcbc_engine #(
        .NUM_LEDS (NUM_LEDS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (advance),
        .i_buttons     (r_in_buttons),
        .i_cfg         (cfg),
        .i_period_load (period_load),
        .o_next        (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_buttons <= i_buttons;
        end
        if (advance) begin
            r_out <= next_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_leds         = r_out.leds;
    assign o_led_position = r_out.led_position;
    assign o_moving_down  = r_out.moving_down;
    assign o_step_period  = r_out.step_period;
    assign o_running      = r_out.running;

    // A waiting tick must not be dropped while the result register is stalled.
    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid)
        else $error("pending tick lost while output stalled");

    // The result register only changes when a tick advances into it.
    a_result_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !advance) |=> $stable(r_out))
        else $error("result changed without an advancing tick");

    // The LED drive is never more than one LED at a time.
    a_leds_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(o_leds))
        else $error("more than one LED lit");

endmodule

@@ verif/chaser_checker.sv @@
`timescale 1ns / 1ps

// Watches the tick, result and register channels of the LED chaser, keeps its
// own copy of the chaser state, and compares every result transfer with the
// oldest outstanding prediction.
module chaser_checker
    import lcbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [BUTTONS_W-1:0]  i_buttons,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [LEDS_W-1:0]     i_leds,
    input  logic [POS_W-1:0]      i_led_position,
    input  logic                  i_moving_down,
    input  logic [PERIOD_W-1:0]   i_step_period,
    input  logic                  i_running,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PERIOD_W-1:0]   i_cfg_data,
    output int                    o_pending,
    output int                    o_failures
);

    localparam int LED_TOTAL  = NUM_LEDS_DEFAULT;
    localparam int MAX_REPORT = 10;

    // Register copies.
    logic [PERIOD_W-1:0]   min_period_r;
    logic [PERIOD_W-1:0]   max_period_r;
    logic [PERIOD_W-1:0]   period_step_r;
    logic [DEBOUNCE_W-1:0] debounce_r;

    // Chaser state.
    logic [LEDS_W-1:0]     lit_pattern;
    int                    led_index;
    logic                  heading_down;
    logic [PERIOD_W-1:0]   period_now;
    logic                  run_enabled;
    logic [PERIOD_W-1:0]   ticks_to_step;
    logic [BUTTONS_W-1:0]  held_word;
    logic [DEBOUNCE_W-1:0] settle_count;
    logic                  word_unsettled;

    t_result display_queue[$];
    int      mismatches;

    task automatic reset_chaser();
        min_period_r   = RST_MIN_PERIOD;
        max_period_r   = RST_MAX_PERIOD;
        period_step_r  = RST_PERIOD_STEP;
        debounce_r     = RST_DEBOUNCE_TICKS;
        lit_pattern    = '0;
        led_index      = 0;
        heading_down   = 1'b0;
        period_now     = RST_INITIAL_PERIOD;
        run_enabled    = 1'b1;
        ticks_to_step  = '0;
        held_word      = '0;
        settle_count   = '0;
        word_unsettled = 1'b0;
    endtask

    task automatic apply_buttons(input logic [BUTTONS_W-1:0] word);
        int v;
        if (word[BIT_REVERSE]) begin
            heading_down = ~heading_down;
        end else if (word[BIT_FASTER]) begin
            v = int'(period_now) - int'(period_step_r);
            if (v < int'(min_period_r)) v = int'(min_period_r);
            period_now = v[PERIOD_W-1:0];
        end else if (word[BIT_SLOWER]) begin
            v = int'(period_now) + int'(period_step_r);
            if (v > int'(max_period_r)) v = int'(max_period_r);
            period_now = v[PERIOD_W-1:0];
        end else if (word[BIT_PAUSE]) begin
            run_enabled   = ~run_enabled;
            ticks_to_step = '0;
        end
    endtask

    // One timer tick: a due step first, then the debounced buttons.
    task automatic advance_chaser(input logic [BUTTONS_W-1:0] word, output t_result shown);
        int p;
        if (run_enabled) begin
            if (ticks_to_step == '0) begin
                p = led_index % LED_TOTAL;
                lit_pattern = LEDS_W'(64'd1 << p);
                if (heading_down) led_index = (p == 0) ? LED_TOTAL - 1 : p - 1;
                else              led_index = (p + 1 >= LED_TOTAL) ? 0 : p + 1;
                ticks_to_step = (period_now == '0) ? '0 : period_now - 1'b1;
            end else begin
                ticks_to_step = ticks_to_step - 1'b1;
            end
        end
        if (word != held_word) begin
            held_word      = word;
            settle_count   = debounce_r;
            word_unsettled = 1'b1;
        end else if (word_unsettled) begin
            if (settle_count <= 1) begin
                word_unsettled = 1'b0;
                settle_count   = '0;
                apply_buttons(word);
            end else begin
                settle_count = settle_count - 1'b1;
            end
        end
        shown.leds         = lit_pattern;
        shown.led_position = POS_W'(led_index);
        shown.moving_down  = heading_down;
        shown.step_period  = period_now;
        shown.running      = run_enabled;
    endtask

    initial begin
        reset_chaser();
        mismatches = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            reset_chaser();
            display_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MIN_PERIOD:     min_period_r  = i_cfg_data;
                    REG_MAX_PERIOD:     max_period_r  = i_cfg_data;
                    REG_INITIAL_PERIOD: period_now    = i_cfg_data;
                    REG_PERIOD_STEP:    period_step_r = i_cfg_data;
                    REG_DEBOUNCE_TICKS: debounce_r    = i_cfg_data[DEBOUNCE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_chaser(i_buttons, want);
                display_queue.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.leds         = i_leds;
                got.led_position = i_led_position;
                got.moving_down  = i_moving_down;
                got.step_period  = i_step_period;
                got.running      = i_running;
                if (display_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%0t: result transfer with nothing outstanding: leds=%h pos=%0d",
                                 $realtime, got.leds, got.led_position);
                end else begin
                    want = display_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT) begin
                            $display("%0t: mismatch exp leds=%h pos=%0d down=%0d period=%0d run=%0d",
                                     $realtime, want.leds, want.led_position,
                                     want.moving_down, want.step_period, want.running);
                            $display("%0t: mismatch got leds=%h pos=%0d down=%0d period=%0d run=%0d",
                                     $realtime, got.leds, got.led_position, got.moving_down,
                                     got.step_period, got.running);
                        end
                    end
                end
            end
        end
        o_pending  <= display_queue.size();
        o_failures <= mismatches;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the LED chaser. The checker instance beside the
// block predicts every result; this module only generates ticks, register
// writes and output back-pressure, and then decides pass or fail.
module testbench;
    import lcbc_pkg::*;

    // Button words built from the bit positions of the package.
    localparam logic [BUTTONS_W-1:0] PRESS_NONE    = '0;
    localparam logic [BUTTONS_W-1:0] PRESS_REVERSE = BUTTONS_W'(1 << BIT_REVERSE);
    localparam logic [BUTTONS_W-1:0] PRESS_FASTER  = BUTTONS_W'(1 << BIT_FASTER);
    localparam logic [BUTTONS_W-1:0] PRESS_SLOWER  = BUTTONS_W'(1 << BIT_SLOWER);
    localparam logic [BUTTONS_W-1:0] PRESS_PAUSE   = BUTTONS_W'(1 << BIT_PAUSE);
    localparam logic [BUTTONS_W-1:0] PRESS_ALL     = '1;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [BUTTONS_W-1:0]  i_buttons      = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [LEDS_W-1:0]     o_leds;
    logic [POS_W-1:0]      o_led_position;
    logic                  o_moving_down;
    logic [PERIOD_W-1:0]   o_step_period;
    logic                  o_running;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [PERIOD_W-1:0]   i_cfg_data     = '0;

    int results_outstanding;
    int failure_count;

    int ticks_sent     = 0;
    int sender_idle    = 6;
    int receiver_idle  = 82;
    int debounce_now   = RST_DEBOUNCE_TICKS;
    int quiet_cycles   = 0;

    always #4 i_clk = ~i_clk;

    led_chaser_with_button_control dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_buttons      (i_buttons),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_leds         (o_leds),
        .o_led_position (o_led_position),
        .o_moving_down  (o_moving_down),
        .o_step_period  (o_step_period),
        .o_running      (o_running),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    chaser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_buttons      (i_buttons),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_leds         (o_leds),
        .i_led_position (o_led_position),
        .i_moving_down  (o_moving_down),
        .i_step_period  (o_step_period),
        .i_running      (o_running),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (results_outstanding),
        .o_failures     (failure_count)
    );

    // The result side stalls at random with the current idle rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // Any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one tick and returns at the edge of its transfer, with valid still
    // high so that a following tick can go out back to back. The idle rates
    // change over the run: sender rarely idle and receiver often stalling, then the reverse,
    // then no idling at all.
    task automatic send_tick(input logic [BUTTONS_W-1:0] word);
        if (ticks_sent < 170) begin
            sender_idle   = 6;
            receiver_idle = 82;
        end else if (ticks_sent < 340) begin
            sender_idle   = 82;
            receiver_idle = 6;
        end else begin
            sender_idle   = 0;
            receiver_idle = 0;
        end
        while ($urandom_range(0, 99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_buttons  <= word;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // Holds off new ticks until every predicted result has been transferred.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [PERIOD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprograms every register once the chaser is idle. A write to an index
    // past the last register is mixed in, which must change nothing.
    task automatic program_chaser(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi,
                                  input logic [PERIOD_W-1:0] start, input logic [PERIOD_W-1:0] delta,
                                  input logic [DEBOUNCE_W-1:0] settle);
        wait_until_drained();
        write_reg(REG_MIN_PERIOD, lo);
        write_reg(REG_MAX_PERIOD, hi);
        write_reg(REG_PERIOD_STEP, delta);
        write_reg(CFG_IDX_W'(REG_DEBOUNCE_TICKS) + CFG_IDX_W'($urandom_range(1, 3)),
                  PERIOD_W'($urandom));
        write_reg(REG_DEBOUNCE_TICKS, {{(PERIOD_W-DEBOUNCE_W){$urandom_range(0, 1) == 1}}, settle});
        write_reg(REG_INITIAL_PERIOD, start);
        debounce_now = settle;
    endtask

    // Mostly presses held long enough to be acted on, with random content,
    // plus random noise words and presses released too early.
    task automatic chase_random(input int count, input int noise_pct);
        int done;
        int hold;
        int release_len;
        logic [BUTTONS_W-1:0] word;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_tick(BUTTONS_W'($urandom_range(0, 15)));
                done++;
            end else begin
                if ($urandom_range(0, 2) != 0)
                    word = BUTTONS_W'(1 << $urandom_range(BIT_REVERSE, BIT_PAUSE));
                else
                    word = BUTTONS_W'($urandom_range(1, 15));
                if (debounce_now > 1 && $urandom_range(0, 99) < 15)
                    hold = $urandom_range(1, debounce_now - 1);
                else
                    hold = ((debounce_now > 1) ? debounce_now : 1) + 1 + $urandom_range(0, 2);
                if (hold > count - done) hold = count - done;
                repeat (hold) send_tick(word);
                done += hold;
                release_len = $urandom_range(1, 3);
                repeat (release_len) send_tick(PRESS_NONE);
                done += release_len;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: the first tick must already take a step.
        send_tick(PRESS_NONE);
        send_tick(PRESS_NONE);

        // Directed part with a short period and a one-tick debounce, so every
        // button acts on the tick after it is pressed.
        program_chaser(16'd1, 16'd4, 16'd2, 16'd1, 8'd1);
        send_tick(PRESS_REVERSE);
        send_tick(PRESS_REVERSE);
        send_tick(PRESS_NONE);
        send_tick(PRESS_NONE);
        send_tick(PRESS_FASTER);
        send_tick(PRESS_FASTER);
        send_tick(PRESS_NONE);
        // Speed up again: the period saturates at the minimum.
        send_tick(PRESS_FASTER);
        send_tick(PRESS_FASTER);
        send_tick(PRESS_SLOWER);
        send_tick(PRESS_SLOWER);
        send_tick(PRESS_NONE);
        // Slow down again: the period goes up to 3, still below the maximum of 4.
        send_tick(PRESS_SLOWER);
        send_tick(PRESS_SLOWER);
        send_tick(PRESS_PAUSE);
        send_tick(PRESS_PAUSE);
        send_tick(PRESS_NONE);
        send_tick(PRESS_NONE);
        // Resume: the next step is due on the following tick.
        send_tick(PRESS_PAUSE);
        send_tick(PRESS_PAUSE);
        // Several buttons at once: reverse wins, then speed up wins.
        send_tick(PRESS_ALL);
        send_tick(PRESS_ALL);
        send_tick(PRESS_ALL & ~PRESS_REVERSE);
        send_tick(PRESS_ALL & ~PRESS_REVERSE);

        // Random part, one register setting per phase.
        program_chaser(16'd1, 16'd8, 16'd3, 16'd1, 8'd2);
        chase_random(110, 15);
        // Zero minimum lets speed up reach a period of zero; debounce set to zero.
        program_chaser(16'd0, 16'd6, 16'd2, 16'd2, 8'd0);
        chase_random(90, 15);
        // Minimum above maximum, each bound checked on its own.
        program_chaser(16'hFFFF, 16'd1, 16'd4, 16'hFFFF, 8'd3);
        chase_random(70, 15);
        // Slow down past the top of the 16-bit range.
        program_chaser(16'd7, 16'hFFFF, 16'd65500, 16'd100, 8'd1);
        chase_random(70, 15);
        program_chaser(16'd2, 16'd12, 16'd1, 16'd3, DEBOUNCE_W'($urandom_range(0, 4)));
        chase_random(50, 20);
        // The sender pauses here until every result is back.
        wait_until_drained();
        chase_random(50, 20);
        // Defaults back, with the longest debounce.
        program_chaser(RST_MIN_PERIOD, RST_MAX_PERIOD, RST_INITIAL_PERIOD, RST_PERIOD_STEP,
                       8'hFF);
        chase_random(40, 50);

        wait_until_drained();
        repeat (4) @(posedge i_clk);
        if (failure_count == 0 && results_outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
